FILE: design/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg - shared types and constants of the PCG32 byte generator
// Field widths, register indexes and the LCG multiplier.
// ----------------------------------------------------------------------------
package pcg_pkg;

	localparam int BYTE_COUNT_W = 9;
	localparam int WORD_W       = 32;
	localparam int VALID_W      = 3;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 64;

	localparam int MAX_REQUEST_BYTES_DEF = 256;

	// LCG multiplier 6364136223846793005
	localparam logic [63:0] PCG_MULT = 64'h5851_F42D_4C95_7F2D;

	typedef logic [BYTE_COUNT_W-1:0] byte_count_t;
	typedef logic [WORD_W-1:0]       word_t;
	typedef logic [VALID_W-1:0]      valid_bytes_t;
	typedef logic [CFG_INDEX_W-1:0]  cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

	// register map
	localparam cfg_index_t REG_ENTROPY_A = 3'd0;
	localparam cfg_index_t REG_ENTROPY_B = 3'd1;
	localparam cfg_index_t REG_ENTROPY_C = 3'd2;
	localparam cfg_index_t REG_ENTROPY_D = 3'd3;

endpackage

FILE: design/pcg_intf.sv
// ----------------------------------------------------------------------------
// pcg_intf - valid/ready channels of the PCG32 byte generator
// Request, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface pcg_req_if;
	import pcg_pkg::*;
	logic        valid;
	logic        ready;
	byte_count_t byte_count;

	modport source (output valid, output byte_count, input ready);
	modport sink   (input valid, input byte_count, output ready);
endinterface

interface pcg_rsp_if;
	import pcg_pkg::*;
	logic         valid;
	logic         ready;
	word_t        random_word;
	valid_bytes_t valid_bytes;
	logic         last_word;

	modport source (output valid, output random_word, output valid_bytes,
		output last_word, input ready);
	modport sink   (input valid, input random_word, input valid_bytes,
		input last_word, output ready);
endinterface

interface pcg_cfg_if;
	import pcg_pkg::*;
	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_data_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/pcg32_random_byte_generator.sv
// ----------------------------------------------------------------------------
// pcg32_random_byte_generator - PCG32 XSH-RR random word source
// Turns a byte-count request into a burst of 32-bit random words.
// ----------------------------------------------------------------------------
//
//  channel | role | payload                               | transfer when
//  --------+------+---------------------------------------+-----------------
//  req     | sink | byte_count[8:0]                       | valid && ready
//  rsp     | src  | random_word[31:0], valid_bytes[2:0],  | valid && ready
//          |      | last_word                             |
//  cfg     | sink | index[2:0], data[63:0]                | valid && ready
//
//  Sequencing: after a request transfers, req stays not ready until each
//  of its words has passed S_EMIT and S_MA to S_MD, so requests do not
//  overlap; the first nonzero request after reset first runs S_SEED.
//  Each word takes an emit step (held by a stalled rsp) and the shared 32x32
//  multiplier (three partial products and the final add of the 64-bit LCG).
//  Reset: arst_n clears the entropy registers, generator state and FSM; no
//  clearing pass is needed. cfg is always ready.
//  Stalls: a stalled rsp holds the emit step; req is taken only when idle,
//  even while the last word of the previous request is still waiting.
//
module pcg32_random_byte_generator #(
	parameter int MAX_REQUEST_BYTES = pcg_pkg::MAX_REQUEST_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pcg_req_if.sink     req,
	pcg_rsp_if.source   rsp,
	pcg_cfg_if.sink     cfg
);
	import pcg_pkg::*;

	// remaining byte counter must hold MAX_REQUEST_BYTES itself
	localparam int          CNT_W   = $clog2(MAX_REQUEST_BYTES + 1);
	localparam byte_count_t MAX_CNT = BYTE_COUNT_W'(MAX_REQUEST_BYTES);

	// one-hot sequencer
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SEED = 7'b0000010,
		S_EMIT = 7'b0000100,
		S_MA   = 7'b0001000,  // lo*lo partial product
		S_MB   = 7'b0010000,  // lo*hi cross term
		S_MC   = 7'b0100000,  // hi*lo cross term
		S_MD   = 7'b1000000   // sum partials and add increment
	} state_t;

	state_t fsm_q;

	// entropy registers
	logic [63:0] ent_a_q, ent_b_q, ent_c_q, ent_d_q;

	// generator
	logic [63:0] gen_q;
	logic [63:0] inc_q;
	logic        seeded_q;
	logic [CNT_W-1:0] rem_q;

	// shared multiplier and partial-sum registers
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [63:0] prod_q;
	logic [63:0] acc_q;

	// output register
	logic         rsp_valid_q;
	word_t        rsp_word_q;
	valid_bytes_t rsp_bytes_q;
	logic         rsp_last_q;

	// ---------------------------------------------------------------- config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_a_q <= '0;
			ent_b_q <= '0;
			ent_c_q <= '0;
			ent_d_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ENTROPY_A: ent_a_q <= cfg.data;
				REG_ENTROPY_B: ent_b_q <= cfg.data;
				REG_ENTROPY_C: ent_c_q <= cfg.data;
				REG_ENTROPY_D: ent_d_q <= cfg.data;
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	// --------------------------------------------------------------- seeding
	// ((x<<1)|1)<<32 keeps only x[30:0]; the low half ORs in the whole
	// 64-bit ((y<<1)|1), so its upper bits land in the upper half too.
	logic [63:0] seed_state, seed_inc;

	assign seed_state = {ent_a_q[30:0], 1'b1, 32'h0} | {ent_b_q[62:0], 1'b1};
	assign seed_inc   = {ent_c_q[30:0], 1'b1, 32'h0} | {ent_d_q[62:0], 1'b1};

	// ------------------------------------------------------------ XSH-RR out
	logic [63:0] xs_mix;
	logic [31:0] xs;
	logic [4:0]  rot;
	logic [63:0] rot_pair;
	word_t       out_word;

	assign xs_mix   = gen_q ^ (gen_q >> 18);
	assign xs       = xs_mix[58:27];
	assign rot      = gen_q[63:59];
	assign rot_pair = {xs, xs} >> rot;
	assign out_word = rot_pair[31:0];

	// ------------------------------------------------------- request counter
	byte_count_t      req_cnt;
	valid_bytes_t     word_bytes;
	logic [CNT_W-1:0] rem_next;
	logic             req_xfer;
	logic             out_free;

	assign req_cnt    = (req.byte_count > MAX_CNT) ? MAX_CNT : req.byte_count;
	assign word_bytes = (rem_q > CNT_W'(3)) ? VALID_W'(4) : VALID_W'(rem_q);
	assign rem_next   = rem_q - CNT_W'(word_bytes);

	assign req.ready = (fsm_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// ------------------------------------------------------------ multiplier
	// gen*M mod 2^64 = lo*mlo + ((lo*mhi + hi*mlo) << 32); hi*mhi drops out
	assign mul_a = (fsm_q == S_MC) ? gen_q[63:32] : gen_q[31:0];
	assign mul_b = (fsm_q == S_MB) ? PCG_MULT[63:32] : PCG_MULT[31:0];
	assign mul_p = mul_a * mul_b;

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q    <= S_IDLE;
			seeded_q <= 1'b0;
			gen_q    <= '0;
			inc_q    <= '0;
			rem_q    <= '0;
		end else begin
			unique case (fsm_q)
				S_IDLE: begin
					if (req_xfer && (req_cnt != '0)) begin
						rem_q <= CNT_W'(req_cnt);
						fsm_q <= seeded_q ? S_EMIT : S_SEED;
					end
				end
				S_SEED: begin
					// first half of seeding; the multiply-add runs as a normal step
					gen_q    <= seed_state + seed_inc;
					inc_q    <= seed_inc;
					seeded_q <= 1'b1;
					fsm_q    <= S_MA;
				end
				S_EMIT: begin
					if (out_free) begin
						rem_q <= rem_next;
						fsm_q <= S_MA;
					end
				end
				S_MA: fsm_q <= S_MB;
				S_MB: fsm_q <= S_MC;
				S_MC: fsm_q <= S_MD;
				S_MD: begin
					gen_q <= acc_q + {prod_q[31:0], 32'h0} + inc_q;
					fsm_q <= (rem_q != '0) ? S_EMIT : S_IDLE;
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

	// partial products, no reset needed
	always_ff @(posedge clk) begin
		if ((fsm_q == S_MA) || (fsm_q == S_MB) || (fsm_q == S_MC)) begin
			prod_q <= mul_p;
		end
		if (fsm_q == S_MB) begin
			acc_q <= prod_q;
		end else if (fsm_q == S_MC) begin
			acc_q <= {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
		end
	end

	// --------------------------------------------------------- output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((fsm_q == S_EMIT) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((fsm_q == S_EMIT) && out_free) begin
			rsp_word_q  <= out_word;
			rsp_bytes_q <= word_bytes;
			rsp_last_q  <= (rem_next == '0);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.random_word = rsp_word_q;
	assign rsp.valid_bytes = rsp_bytes_q;
	assign rsp.last_word   = rsp_last_q;

	// ------------------------------------------------------------ assertions
	a_emit_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == S_EMIT) |-> (rem_q != '0))
		else $error("emit step entered with no bytes left");

	a_seed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(seeded_q))
		else $error("seeded flag dropped without reset");

	a_full_unless_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.last_word) |-> (rsp.valid_bytes == VALID_W'(4)))
		else $error("partial word not marked last");

	a_first_seeds: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && (req_cnt != '0) && !seeded_q) |=> (fsm_q == S_SEED))
		else $error("first request did not seed the generator");

endmodule

FILE: bench/pcg32_random_byte_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcg32_random_byte_generator_test - self-checking bench for the PCG32 source
// Drives byte-count requests and entropy writes, predicts every random word
// with a local XSH-RR generator and checks each returned transfer in order.
// ----------------------------------------------------------------------------
module pcg32_random_byte_generator_test;
	import pcg_pkg::*;

	localparam int MAX_BYTES     = MAX_REQUEST_BYTES_DEF;
	localparam int SETTLE_CYCLES = 40;      // tail of the LCG update after the last word
	localparam int HOLD_CYCLES   = 600;     // long receiver back-off
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int NUM_INDEXES   = 2 ** CFG_INDEX_W;

	// one expected output word
	typedef struct {
		word_t        word;
		valid_bytes_t nbytes;
		logic         last;
	} rand_word_t;

	// one entropy register write
	typedef struct {
		cfg_index_t index;
		cfg_data_t  data;
	} reg_write_t;

	logic clk;
	logic arst_n;

	pcg_req_if req_if ();
	pcg_rsp_if rsp_if ();
	pcg_cfg_if cfg_if ();

	pcg32_random_byte_generator #(
		.MAX_REQUEST_BYTES(MAX_BYTES)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if),
		.cfg   (cfg_if)
	);

	// stimulus queues, filled by the sequence below at the falling edge
	byte_count_t request_q[$];
	reg_write_t  reg_write_q[$];
	// words still owed by the block, oldest first
	rand_word_t  word_fifo[$];

	// local copy of the generator
	cfg_data_t   ent_a, ent_b, ent_c, ent_d;
	logic [63:0] lcg_state;
	logic [63:0] lcg_inc;
	bit          lcg_seeded;

	// idling controls
	bit          sender_idle;
	bit          receiver_idle;
	int unsigned hold_kick, hold_seen;
	int          hold_left;
	int          send_gap, send_gap_now;
	int          recv_gap, recv_gap_now;

	// bookkeeping
	int unsigned errors;
	int unsigned requests_sent;
	int unsigned words_checked;
	int unsigned bytes_checked;
	int unsigned reg_writes;
	int unsigned cycle_count;

	int unsigned directed_counts [20] = '{1, 2, 3, 4, 5, 7, 8, 0, 256, 257,
		511, 300, 255, 253, 252, 6, 9, 16, 64, 128};

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor: one request in, zero or more words pushed onto word_fifo.
	// Seeding happens on the first non-empty request only; the entropy
	// registers are sampled at that transfer and never again.
	// ------------------------------------------------------------------------
	function automatic void predict_request(byte_count_t count);
		int unsigned  left;
		int unsigned  rot;
		valid_bytes_t take;
		logic [63:0]  old;
		word_t        xs;
		word_t        w;
		rand_word_t   item;

		left = count;
		if (left > MAX_BYTES)
			left = MAX_BYTES;       // oversize requests are clamped
		if (left == 0)
			return;                 // nothing out, and no seeding either
		if (!lcg_seeded) begin
			// halves are ORed, so the upper bits of b bleed into the top half
			lcg_state  = (((ent_a << 1) | 64'd1) << 32) | ((ent_b << 1) | 64'd1);
			lcg_inc    = (((ent_c << 1) | 64'd1) << 32) | ((ent_d << 1) | 64'd1);
			lcg_state  = lcg_state + lcg_inc;
			lcg_state  = lcg_state * PCG_MULT;
			lcg_state  = lcg_state + lcg_inc;
			lcg_seeded = 1'b1;
		end
		while (left > 0) begin
			take      = (left > 3) ? valid_bytes_t'(4) : valid_bytes_t'(left);
			old       = lcg_state;
			lcg_state = old * PCG_MULT + lcg_inc;
			// XSH-RR output: xorshift high, then rotate by the top five bits
			xs        = word_t'(((old >> 18) ^ old) >> 27);
			rot       = old[63:59];
			w         = (xs >> rot) | (xs << ((32 - rot) & 31));
			left      = left - take;
			item.word   = w;
			item.nbytes = take;
			item.last   = (left == 0);
			word_fifo.push_back(item);
		end
	endfunction

	function automatic int draw_wait(bit idle_on);
		return idle_on ? int'($urandom_range(0, 14)) : 0;
	endfunction

	// biased towards short requests so that most of the run stays quick
	function automatic byte_count_t random_count();
		int unsigned pick;

		pick = $urandom_range(0, 99);
		if (pick < 5)
			return '0;
		else if (pick < 70)
			return byte_count_t'($urandom_range(1, 16));
		else if (pick < 88)
			return byte_count_t'($urandom_range(17, 255));
		else
			return byte_count_t'($urandom_range(256, 511));
	endfunction

	function automatic cfg_data_t random_data();
		return {$urandom, $urandom};
	endfunction

	// ------------------------------------------------------------------------
	// Request driver. A transfer is predicted at the edge it happens on;
	// the gap before the next request is drawn at that moment too.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid      <= 1'b0;
			req_if.byte_count <= '0;
			send_gap          <= 0;
		end else begin
			send_gap_now = send_gap;
			if (req_if.valid && req_if.ready) begin
				predict_request(req_if.byte_count);
				requests_sent++;
				send_gap_now = draw_wait(sender_idle);
			end
			if (req_if.valid && !req_if.ready) begin
				// offer stands until taken
			end else if (send_gap_now != 0) begin
				req_if.valid <= 1'b0;
				send_gap     <= send_gap_now - 1;
			end else if (request_q.size() != 0) begin
				req_if.valid      <= 1'b1;
				req_if.byte_count <= request_q.pop_front();
				send_gap          <= 0;
			end else begin
				req_if.valid <= 1'b0;
				send_gap     <= 0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Entropy register writer; the local copy follows each transfer.
	// Indexes past the last register are dropped, as the block does.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_if.valid <= 1'b0;
			cfg_if.index <= REG_ENTROPY_A;
			cfg_if.data  <= '0;
		end else begin
			if (cfg_if.valid && cfg_if.ready) begin
				reg_writes++;
				case (cfg_if.index)
				REG_ENTROPY_A: ent_a = cfg_if.data;
				REG_ENTROPY_B: ent_b = cfg_if.data;
				REG_ENTROPY_C: ent_c = cfg_if.data;
				REG_ENTROPY_D: ent_d = cfg_if.data;
				default: ;
				endcase
			end
			if (cfg_if.valid && !cfg_if.ready) begin
				// hold
			end else if (reg_write_q.size() != 0) begin
				cfg_if.valid <= 1'b1;
				cfg_if.index <= reg_write_q[0].index;
				cfg_if.data  <= reg_write_q[0].data;
				void'(reg_write_q.pop_front());
			end else begin
				cfg_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Long receiver back-off, counted here; started by bumping hold_kick
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_kick != hold_seen) begin
			hold_left <= HOLD_CYCLES;
			hold_seen <= hold_kick;
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor: drives ready and checks each transfer against the
	// oldest owed word, field by field.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			recv_gap     <= 0;
		end else begin
			recv_gap_now = recv_gap;
			if (rsp_if.valid && rsp_if.ready) begin
				if (word_fifo.size() == 0) begin
					$display("%0t: unexpected word %h bytes %0d last %b", $time,
						rsp_if.random_word, rsp_if.valid_bytes, rsp_if.last_word);
					errors++;
				end else begin
					if (rsp_if.random_word !== word_fifo[0].word) begin
						$display("%0t: random_word expected %h actual %h", $time,
							word_fifo[0].word, rsp_if.random_word);
						errors++;
					end
					if (rsp_if.valid_bytes !== word_fifo[0].nbytes) begin
						$display("%0t: valid_bytes expected %0d actual %0d", $time,
							word_fifo[0].nbytes, rsp_if.valid_bytes);
						errors++;
					end
					if (rsp_if.last_word !== word_fifo[0].last) begin
						$display("%0t: last_word expected %b actual %b", $time,
							word_fifo[0].last, rsp_if.last_word);
						errors++;
					end
					bytes_checked += word_fifo[0].nbytes;
					void'(word_fifo.pop_front());
				end
				words_checked++;
				recv_gap_now = draw_wait(receiver_idle);
			end
			if (hold_left != 0) begin
				rsp_if.ready <= 1'b0;
				recv_gap     <= recv_gap_now;
			end else if (recv_gap_now != 0) begin
				rsp_if.ready <= 1'b0;
				recv_gap     <= recv_gap_now - 1;
			end else begin
				rsp_if.ready <= 1'b1;
				recv_gap     <= 0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence helpers, all synchronised to the falling edge
	// ------------------------------------------------------------------------
	task automatic write_reg(cfg_index_t index, cfg_data_t data);
		reg_write_t w;

		w.index = index;
		w.data  = data;
		@(negedge clk);
		reg_write_q.push_back(w);
		do @(negedge clk); while (reg_write_q.size() != 0 || cfg_if.valid);
	endtask

	// wait until every request is taken and every word returned; with
	// settle set, also let the block finish its last state update
	task automatic wait_for_quiet(bit settle);
		do @(negedge clk);
		while (request_q.size() != 0 || req_if.valid || word_fifo.size() != 0);
		if (settle)
			repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_random(int unsigned count);
		@(negedge clk);
		repeat (count) request_q.push_back(random_count());
	endtask

	// random values in all four registers and in one of the unused indexes
	task automatic scramble_regs();
		write_reg(REG_ENTROPY_A, random_data());
		write_reg(REG_ENTROPY_B, random_data());
		write_reg(REG_ENTROPY_C, random_data());
		write_reg(REG_ENTROPY_D, random_data());
		write_reg(cfg_index_t'($urandom_range(REG_ENTROPY_D + 1, NUM_INDEXES - 1)),
			random_data());
	endtask

	// ------------------------------------------------------------------------
	// Timeout
	// ------------------------------------------------------------------------
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d words still owed", cycle_count,
			word_fifo.size());
		$display("pcg32_random_byte_generator regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned pick;

		// channel outputs of the bench are set by their own processes in reset
		arst_n = 1'b0;
		ent_a = '0;
		ent_b = '0;
		ent_c = '0;
		ent_d = '0;
		lcg_state     = '0;
		lcg_inc       = '0;
		lcg_seeded    = 1'b0;
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		hold_kick     = 0;
		errors        = 0;
		requests_sent = 0;
		words_checked = 0;
		bytes_checked = 0;
		reg_writes    = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every index with all ones, then the four registers back to zero
		for (int i = 0; i < NUM_INDEXES; i++)
			write_reg(cfg_index_t'(i), '1);
		write_reg(REG_ENTROPY_A, '0);
		write_reg(REG_ENTROPY_B, '0);
		write_reg(REG_ENTROPY_C, '0);
		write_reg(REG_ENTROPY_D, '0);
		scramble_regs();

		// an empty request must not seed, so the writes after it still count
		@(negedge clk);
		request_q.push_back('0);
		wait_for_quiet(1);

		// seed values: per register zero, all ones or random
		pick = $urandom_range(0, 2);
		write_reg(REG_ENTROPY_A, pick == 0 ? '0 : pick == 1 ? '1 : random_data());
		pick = $urandom_range(0, 2);
		write_reg(REG_ENTROPY_B, pick == 0 ? '0 : pick == 1 ? '1 : random_data());
		pick = $urandom_range(0, 2);
		write_reg(REG_ENTROPY_C, pick == 0 ? '0 : pick == 1 ? '1 : random_data());
		pick = $urandom_range(0, 2);
		write_reg(REG_ENTROPY_D, pick == 0 ? '0 : pick == 1 ? '1 : random_data());

		// directed counts: sizes around word edges, clamping, the maximum
		@(negedge clk);
		foreach (directed_counts[i])
			request_q.push_back(byte_count_t'(directed_counts[i]));
		wait_for_quiet(1);

		// writes once seeded are stored but must not disturb the sequence
		scramble_regs();
		write_reg(REG_ENTROPY_A, '1);
		write_reg(REG_ENTROPY_D, '0);

		// random traffic, no idling on either side
		send_random(22);
		wait_for_quiet(1);
		scramble_regs();

		// sender gaps only, with a full drain half way through
		sender_idle = 1'b1;
		send_random(11);
		wait_for_quiet(0);
		send_random(11);
		wait_for_quiet(1);
		scramble_regs();

		// receiver stalls only
		sender_idle   = 1'b0;
		receiver_idle = 1'b1;
		send_random(22);
		wait_for_quiet(1);

		// long back-off at the output while requests keep coming, so the
		// block backs up and refuses new requests
		receiver_idle = 1'b0;
		@(negedge clk);
		hold_kick++;
		send_random(10);
		wait_for_quiet(1);
		write_reg(REG_ENTROPY_B, '1);
		write_reg(REG_ENTROPY_C, '0);

		// both sides idling at random
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
		send_random(22);
		wait_for_quiet(1);

		if (word_fifo.size() != 0) begin
			$display("%0d words never returned", word_fifo.size());
			errors++;
		end

		$display("covered %0d requests, %0d words (%0d bytes), %0d register writes",
			requests_sent, words_checked, bytes_checked, reg_writes);
		$display("seeding after an empty request, clamping, idle and back-off phases");
		if (errors == 0)
			$display("pcg32_random_byte_generator regression: pass");
		else
			$display("pcg32_random_byte_generator regression: fail");
		$finish;
	end

endmodule
